[rtl/core/dfu_pkg.sv]
`timescale 1ns / 1ps

package dfu_pkg;

  localparam int MAX_TRANSFER = 2048;
  localparam int SECTOR_COUNT = 12;
  localparam int QUEUE_DEPTH  = 4;
  localparam int MAX_RES      = 3;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 80;

  localparam logic [3:0] SEC_LAST = 4'(SECTOR_COUNT - 1);

  localparam logic [7:0] CMD_DNLOAD    = 8'd1;
  localparam logic [7:0] CMD_GETSTATUS = 8'd3;
  localparam logic [7:0] CMD_CLRSTATUS = 8'd4;
  localparam logic [7:0] CMD_GETSTATE  = 8'd5;
  localparam logic [7:0] CMD_ABORT     = 8'd6;

  localparam logic [6:0] REQ_TYPE_CLASS = 7'h21;
  localparam logic [7:0] CODE_SETADDR   = 8'h21;
  localparam logic [7:0] CODE_ERASE     = 8'h41;

  localparam logic [2:0] OP_NONE      = 3'd0;
  localparam logic [2:0] OP_UNPROTECT = 3'd1;
  localparam logic [2:0] OP_ERASE     = 3'd2;
  localparam logic [2:0] OP_PROGRAM   = 3'd3;
  localparam logic [2:0] OP_RESET     = 3'd4;

  localparam logic [1:0] CFG_APP_BASE   = 2'd0;
  localparam logic [1:0] CFG_BLOCK_SIZE = 2'd1;
  localparam logic [1:0] CFG_POLL       = 2'd2;

  localparam logic [31:0] APP_BASE_RST   = 32'h0800_4000;
  localparam logic [11:0] BLOCK_SIZE_RST = 12'd2048;
  localparam logic [23:0] POLL_RST       = 24'd70;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd2,
    ST_DN_SYNC  = 4'd3,
    ST_DN_BUSY  = 4'd4,
    ST_DN_IDLE  = 4'd5,
    ST_MAN_SYNC = 4'd6,
    ST_MAN      = 4'd7,
    ST_ERROR    = 4'd10
  } dfu_state_t;

  typedef struct packed {
    logic [31:0] first_word;
    logic [7:0]  first_byte;
    logic [11:0] payload_length;
    logic [15:0] block_num;
    logic [7:0]  request_type;
  } req_t;

  typedef struct packed {
    logic [9:0]  word_count;
    logic [3:0]  sector_index;
    logic [31:0] flash_address;
    logic [2:0]  flash_op;
    logic [3:0]  reply_state;
    logic [23:0] poll_timeout;
    logic        accepted;
  } res_data_t;

  typedef struct packed {
    logic      last;
    logic      kind;
    res_data_t data;
  } res_t;

  typedef struct packed {
    logic [31:0] app_base;
    logic [11:0] block_size;
    logic [23:0] poll_dflt;
  } cfg_t;

  function automatic logic [31:0] sec_base(input logic [3:0] idx);
    logic [31:0] b;
    unique case (idx)
      4'd0:    b = 32'h0800_0000;
      4'd1:    b = 32'h0800_4000;
      4'd2:    b = 32'h0800_8000;
      4'd3:    b = 32'h0800_C000;
      4'd4:    b = 32'h0801_0000;
      4'd5:    b = 32'h0802_0000;
      4'd6:    b = 32'h0804_0000;
      4'd7:    b = 32'h0806_0000;
      4'd8:    b = 32'h0808_0000;
      4'd9:    b = 32'h080A_0000;
      4'd10:   b = 32'h080C_0000;
      4'd11:   b = 32'h080E_0000;
      4'd12:   b = 32'h0810_0000;
      4'd13:   b = 32'h0812_0000;
      4'd14:   b = 32'h0814_0000;
      default: b = 32'h0816_0000;
    endcase
    return b;
  endfunction

  function automatic logic [23:0] sec_time(input logic [3:0] idx);
    logic [23:0] t;
    case (idx) inside
      4'd0, 4'd2, 4'd3: t = 24'd500;
      4'd1, 4'd4:       t = 24'd1000;
      default:          t = 24'd1500;
    endcase
    return t;
  endfunction

endpackage

[rtl/core/dfu_cfg.sv]
`timescale 1ns / 1ps

module dfu_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output dfu_pkg::cfg_t     cfg,
  output logic [11:0]       bs_nxt
);
  import dfu_pkg::*;

  logic [31:0] app_base_r;
  logic [11:0] block_size_r;
  logic [23:0] poll_r;
  logic        wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      app_base_r   <= APP_BASE_RST;
      block_size_r <= BLOCK_SIZE_RST;
      poll_r       <= POLL_RST;
    end else if (wr) begin
      unique case (cfg_index)
        CFG_APP_BASE:   app_base_r   <= cfg_data;
        CFG_BLOCK_SIZE: block_size_r <= cfg_data[11:0];
        CFG_POLL:       poll_r       <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // block size as it will be after this edge, for the block offset product
  assign bs_nxt = (wr && cfg_index == CFG_BLOCK_SIZE) ? cfg_data[11:0] : block_size_r;

  assign cfg.app_base   = app_base_r;
  assign cfg.block_size = block_size_r;
  assign cfg.poll_dflt  = poll_r;

endmodule

[rtl/core/dfu_core.sv]
`timescale 1ns / 1ps

module dfu_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_cmd,
  input  dfu_pkg::req_t                     in_req,
  input  dfu_pkg::cfg_t                     cfg,
  input  logic [11:0]                       bs_nxt,
  input  logic                              room,
  output logic                              push,
  output logic [1:0]                        push_n,
  output dfu_pkg::res_t [dfu_pkg::MAX_RES-1:0] push_res
);
  import dfu_pkg::*;

  logic        vld_r;
  logic [7:0]  cmd_r;
  req_t        req_r;
  logic        take;

  dfu_state_t  st_r, st_nxt;
  logic [3:0]  nsec_r, nsec_nxt;
  logic [15:0] lblk_r, lblk_nxt;
  logic [11:0] llen_r, llen_nxt;
  logic [7:0]  lcmd_r, lcmd_nxt;
  logic [31:0] larg_r, larg_nxt;
  logic [31:0] aptr_r, aptr_nxt;
  logic [31:0] prod_r;

  logic signed [16:0] blk_off;
  logic signed [12:0] bs_s;
  logic signed [29:0] prod_full;

  logic        rt_ok;
  logic [3:0]  cur_sec;
  logic        sec_hit;
  logic        erase0;
  logic [31:0] prg_base;
  logic        prg_ok;
  logic [10:0] wc_full;
  logic [9:0]  wc;

  logic        acc;
  dfu_state_t  rep_state;
  dfu_state_t  fl_state;
  logic [23:0] pt;
  logic        do_unp, do_ers, do_prg, do_rst;
  logic [2:0]  fl_op;
  logic [1:0]  n_flash;

  // input register
  assign take     = vld_r && room;
  assign in_ready = !vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd_r <= in_cmd;
      req_r <= in_req;
    end
  end

  // (block - 2) * block_size kept in step with the latched block and config
  assign blk_off   = $signed({1'b0, lblk_nxt}) - 17'sd2;
  assign bs_s      = $signed({1'b0, bs_nxt});
  assign prod_full = blk_off * bs_s;

  always_ff @(posedge clk) begin
    prod_r <= {{2{prod_full[29]}}, prod_full};
  end

  assign rt_ok    = req_r.request_type[6:0] == REQ_TYPE_CLASS;
  assign cur_sec  = (nsec_r > SEC_LAST) ? SEC_LAST : nsec_r;
  assign sec_hit  = larg_r == sec_base(cur_sec);
  assign erase0   = (lblk_r == 16'd0) && (lcmd_r == CODE_ERASE);
  assign prg_base = aptr_r + prod_r;
  assign prg_ok   = prg_base >= cfg.app_base;
  assign wc_full  = 11'(({1'b0, llen_r} + 13'd3) >> 2);
  assign wc       = (wc_full > 11'd1023) ? 10'd1023 : wc_full[9:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      nsec_r <= 4'd1;
      lblk_r <= '0;
      llen_r <= '0;
      lcmd_r <= '0;
      larg_r <= '0;
      aptr_r <= '0;
    end else begin
      st_r   <= st_nxt;
      nsec_r <= nsec_nxt;
      lblk_r <= lblk_nxt;
      llen_r <= llen_nxt;
      lcmd_r <= lcmd_nxt;
      larg_r <= larg_nxt;
      aptr_r <= aptr_nxt;
    end
  end

  always_comb begin
    st_nxt    = st_r;
    nsec_nxt  = nsec_r;
    lblk_nxt  = lblk_r;
    llen_nxt  = llen_r;
    lcmd_nxt  = lcmd_r;
    larg_nxt  = larg_r;
    aptr_nxt  = aptr_r;
    acc       = 1'b0;
    rep_state = st_r;
    fl_state  = ST_DN_IDLE;
    pt        = '0;
    do_unp    = 1'b0;
    do_ers    = 1'b0;
    do_prg    = 1'b0;
    do_rst    = 1'b0;
    if (take && rt_ok) begin
      unique case (cmd_r)
        CMD_DNLOAD: begin
          acc = 1'b1;
          if (req_r.payload_length == 12'd0) begin
            st_nxt = ST_MAN_SYNC;
          end else begin
            lblk_nxt = req_r.block_num;
            llen_nxt = ({1'b0, req_r.payload_length} > 13'(MAX_TRANSFER)) ?
                       12'(MAX_TRANSFER) : req_r.payload_length;
            lcmd_nxt = req_r.first_byte;
            larg_nxt = req_r.first_word;
            st_nxt   = ST_DN_SYNC;
          end
          rep_state = st_nxt;
        end
        CMD_CLRSTATUS: begin
          acc = 1'b1;
          if (st_r == ST_ERROR) begin
            st_nxt = ST_IDLE;
          end
          rep_state = st_nxt;
        end
        CMD_ABORT: begin
          acc       = 1'b1;
          st_nxt    = ST_IDLE;
          rep_state = ST_IDLE;
        end
        CMD_GETSTATE: begin
          acc = 1'b1;
        end
        CMD_GETSTATUS: begin
          acc = 1'b1;
          if (st_r == ST_DN_SYNC) begin
            rep_state = ST_DN_BUSY;
            pt        = (erase0 && sec_hit) ? sec_time(cur_sec) : cfg.poll_dflt;
            st_nxt    = ST_DN_IDLE;
            if (lblk_r == 16'd0) begin
              if (lcmd_r == CODE_ERASE) begin
                do_unp = larg_r == cfg.app_base;
                do_ers = sec_hit && (larg_r >= cfg.app_base);
                if (do_ers && cur_sec < SEC_LAST) begin
                  nsec_nxt = cur_sec + 4'd1;
                end
              end
              // erase falls through into set address
              if (lcmd_r == CODE_ERASE || lcmd_r == CODE_SETADDR) begin
                aptr_nxt = larg_r;
              end
            end else begin
              do_prg = prg_ok;
            end
          end else if (st_r == ST_MAN_SYNC) begin
            rep_state = ST_MAN;
            fl_state  = ST_IDLE;
            do_rst    = 1'b1;
            st_nxt    = ST_IDLE;
            nsec_nxt  = 4'd1;
            lblk_nxt  = '0;
            llen_nxt  = '0;
            lcmd_nxt  = '0;
            larg_nxt  = '0;
            aptr_nxt  = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // result words: reply, then up to two flash commands
  always_comb begin
    fl_op = do_unp ? OP_UNPROTECT :
            do_ers ? OP_ERASE :
            do_prg ? OP_PROGRAM :
            do_rst ? OP_RESET : OP_NONE;
    n_flash = 2'(do_unp) + 2'(do_ers) + 2'(do_prg) + 2'(do_rst);

    push_res = '0;

    push_res[0].kind              = 1'b0;
    push_res[0].data.accepted     = acc;
    push_res[0].data.poll_timeout = pt;
    push_res[0].data.reply_state  = rep_state;
    push_res[0].last              = n_flash == 2'd0;

    push_res[1].kind               = 1'b1;
    push_res[1].data.accepted      = 1'b1;
    push_res[1].data.reply_state   = fl_state;
    push_res[1].data.flash_op      = fl_op;
    push_res[1].data.flash_address = (fl_op == OP_PROGRAM) ? prg_base : '0;
    push_res[1].data.sector_index  = (fl_op == OP_ERASE) ? cur_sec : '0;
    push_res[1].data.word_count    = (fl_op == OP_PROGRAM) ? wc : '0;
    push_res[1].last               = n_flash == 2'd1;

    // second flash word only ever follows an unprotect
    push_res[2].kind              = 1'b1;
    push_res[2].data.accepted     = 1'b1;
    push_res[2].data.reply_state  = ST_DN_IDLE;
    push_res[2].data.flash_op     = OP_ERASE;
    push_res[2].data.sector_index = cur_sec;
    push_res[2].last              = 1'b1;
  end

  assign push   = take;
  assign push_n = 2'd1 + n_flash;

endmodule

[rtl/core/dfu_queue.sv]
`timescale 1ns / 1ps

module dfu_queue (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  input  logic [1:0]                           push_n,
  input  dfu_pkg::res_t [dfu_pkg::MAX_RES-1:0] push_res,
  output logic                                 room,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output dfu_pkg::res_t                        out_res
);
  import dfu_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  res_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && out_ready;
  assign out_res   = mem[rd_r];

  // room for a full set of results once this cycle's word has left
  assign room = (cnt_r <= CNT_W'(QUEUE_DEPTH - MAX_RES)) ||
                (pop && cnt_r == CNT_W'(QUEUE_DEPTH - MAX_RES + 1));

  assign cnt_nxt = cnt_r - CNT_W'(pop) + (push ? CNT_W'(push_n) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + PTR_W'(push_n);
      end
      if (pop) begin
        rd_r <= rd_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_RES; j++) begin
      if (push && 2'(j) < push_n) begin
        mem[PTR_W'(wr_r + PTR_W'(j))] <= push_res[j];
      end
    end
  end

endmodule

[rtl/core/dfu_download_state_machine_top.sv]
`timescale 1ns / 1ps

// DFU class request handler.
// in_*  : one word per setup request. in_tuser carries the request code,
//         in_tdata the request type, block number, length, first payload
//         byte and first payload word.
// out_* : one or more words per request. The first is always the reply to
//         the host (out_tuser = 0); a GETSTATUS that completes a download
//         block or the manifest phase adds up to two flash commands
//         (out_tuser = 1). out_tlast marks the last word of a request.
// cfg_* : register writes, always ready; write only while no request is
//         in flight.
// Flow:   a request waits in the input register until the queue has room;
//         words leave the queue one per cycle while out_tready is high.
// Throughput: one request per cycle while each gives a single word; the
//         four-entry result queue takes a request only when it can hold
//         three words, so output bandwidth of one word per cycle sets it.
// Reset: the DFU state returns to dfuIDLE, next sector to 1, latched
//         header and address pointer to zero, registers to defaults.
// A stalled receiver holds the head word; the queue and the input
//         register absorb the next request before in_tready drops.
module dfu_download_state_machine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // request_type, block_num, payload_length, first_byte, first_word
  input  logic [dfu_pkg::IN_DATA_W-1:0] in_tdata,
  // cmd
  input  logic [7:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // accepted, poll_timeout, reply_state, flash_op, flash_address,
  // sector_index, word_count
  output logic [dfu_pkg::OUT_DATA_W-1:0] out_tdata,
  // result_kind
  output logic        out_tuser,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import dfu_pkg::*;

  cfg_t                cfg;
  logic [11:0]         bs_nxt;
  req_t                req;
  logic                room;
  logic                push;
  logic [1:0]          push_n;
  res_t [MAX_RES-1:0]  push_res;
  res_t                head;

  assign req = req_t'(in_tdata[$bits(req_t)-1:0]);

  dfu_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .bs_nxt    (bs_nxt)
  );

  dfu_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_tuser),
    .in_req   (req),
    .cfg      (cfg),
    .bs_nxt   (bs_nxt),
    .room     (room),
    .push     (push),
    .push_n   (push_n),
    .push_res (push_res)
  );

  dfu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_n    (push_n),
    .push_res  (push_res),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (head)
  );

  assign out_tdata = OUT_DATA_W'(head.data);
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

[rtl/core/dfu_chk.sv]
`timescale 1ns / 1ps

module dfu_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  a_flash_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[0] && out_tdata[24:1] == 24'd0)
    else $error("flash command not marked accepted or carries a timeout");

  a_reply_noop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[31:29] == 3'd0 &&
    out_tdata[63:32] == 32'd0 && out_tdata[77:64] == 14'd0)
    else $error("reply carries flash fields");

  a_stall_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tlast && !out_tuser)
    else $error("stall reply followed by more words");

endmodule

bind dfu_download_state_machine_top dfu_chk u_dfu_chk (.*);

[tb/dfu_response_checker.sv]
`timescale 1ns / 1ps

module dfu_response_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [dfu_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [7:0]                     in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [dfu_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           out_tuser,
  input  logic                           out_tlast,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [31:0]                    cfg_data,
  output int                             errors,
  output int                             pending
);
  import dfu_pkg::*;

  localparam logic [31:0] SEC_START [16] = '{
    32'h0800_0000, 32'h0800_4000, 32'h0800_8000, 32'h0800_C000,
    32'h0801_0000, 32'h0802_0000, 32'h0804_0000, 32'h0806_0000,
    32'h0808_0000, 32'h080A_0000, 32'h080C_0000, 32'h080E_0000,
    32'h0810_0000, 32'h0812_0000, 32'h0814_0000, 32'h0816_0000};
  localparam logic [23:0] SECTOR_MS [16] = '{
    24'd500,  24'd1000, 24'd500,  24'd500,  24'd1000, 24'd1500, 24'd1500, 24'd1500,
    24'd1500, 24'd1500, 24'd1500, 24'd1500, 24'd1500, 24'd1500, 24'd1500, 24'd1500};

  logic [31:0] app_base;
  logic [11:0] blk_size;
  logic [23:0] poll_dflt;

  dfu_state_t  dfu_st;
  logic [3:0]  next_sector;
  logic [15:0] hdr_block;
  logic [11:0] hdr_len;
  logic [7:0]  hdr_cmd;
  logic [31:0] hdr_arg;
  logic [31:0] addr_ptr;

  res_t        response_due[$];
  res_t        burst[3];
  int          burst_n;
  int          fails = 0;
  res_t        want;
  res_data_t   got;

  function automatic void clear_session();
    dfu_st      = ST_IDLE;
    next_sector = 4'd1;
    hdr_block   = '0;
    hdr_len     = '0;
    hdr_cmd     = '0;
    hdr_arg     = '0;
    addr_ptr    = '0;
  endfunction

  function automatic void queue_word(input logic kind, input logic acc,
                                     input logic [23:0] wait_ms, input logic [2:0] op,
                                     input logic [31:0] addr, input logic [3:0] sec,
                                     input logic [9:0] wc);
    res_t w;
    w.last               = 1'b0;
    w.kind               = kind;
    w.data.accepted      = acc;
    w.data.poll_timeout  = wait_ms;
    w.data.reply_state   = dfu_st;
    w.data.flash_op      = op;
    w.data.flash_address = addr;
    w.data.sector_index  = sec;
    w.data.word_count    = wc;
    burst[burst_n] = w;
    burst_n++;
  endfunction

  function automatic void predict_response(input logic [7:0] code, input req_t rq);
    logic [23:0] wait_ms;
    logic [3:0]  sec;
    logic [31:0] blk_off;
    logic [31:0] run_base;
    logic [31:0] words;
    int          k;
    burst_n = 0;
    sec = (next_sector > SEC_LAST) ? SEC_LAST : next_sector;
    if (rq.request_type[6:0] != REQ_TYPE_CLASS) begin
      queue_word(1'b0, 1'b0, '0, OP_NONE, '0, '0, '0);
    end else begin
      case (code)
        CMD_DNLOAD: begin
          if (rq.payload_length == 12'd0) begin
            dfu_st = ST_MAN_SYNC;
          end else begin
            hdr_block = rq.block_num;
            hdr_len   = (rq.payload_length > 12'(MAX_TRANSFER)) ? 12'(MAX_TRANSFER)
                                                                : rq.payload_length;
            hdr_cmd   = rq.first_byte;
            hdr_arg   = rq.first_word;
            dfu_st    = ST_DN_SYNC;
          end
          queue_word(1'b0, 1'b1, '0, OP_NONE, '0, '0, '0);
        end
        CMD_CLRSTATUS: begin
          if (dfu_st == ST_ERROR) dfu_st = ST_IDLE;
          queue_word(1'b0, 1'b1, '0, OP_NONE, '0, '0, '0);
        end
        CMD_ABORT: begin
          dfu_st = ST_IDLE;
          queue_word(1'b0, 1'b1, '0, OP_NONE, '0, '0, '0);
        end
        CMD_GETSTATE: begin
          queue_word(1'b0, 1'b1, '0, OP_NONE, '0, '0, '0);
        end
        CMD_GETSTATUS: begin
          wait_ms = '0;
          if (dfu_st == ST_DN_SYNC) begin
            dfu_st  = ST_DN_BUSY;
            wait_ms = poll_dflt;
            if (hdr_block == 16'd0 && hdr_cmd == CODE_ERASE && hdr_arg == SEC_START[sec])
              wait_ms = SECTOR_MS[sec];
          end else if (dfu_st == ST_MAN_SYNC) begin
            dfu_st = ST_MAN;
          end
          queue_word(1'b0, 1'b1, wait_ms, OP_NONE, '0, '0, '0);
          if (dfu_st == ST_DN_BUSY) begin
            dfu_st = ST_DN_IDLE;
            if (hdr_block == 16'd0) begin
              if (hdr_cmd == CODE_ERASE) begin
                if (hdr_arg == app_base)
                  queue_word(1'b1, 1'b1, '0, OP_UNPROTECT, '0, '0, '0);
                if (hdr_arg == SEC_START[sec] && hdr_arg >= app_base) begin
                  queue_word(1'b1, 1'b1, '0, OP_ERASE, '0, sec, '0);
                  if (sec < SEC_LAST) next_sector = sec + 4'd1;
                end
              end
              if (hdr_cmd == CODE_ERASE || hdr_cmd == CODE_SETADDR) addr_ptr = hdr_arg;
            end else begin
              blk_off  = {16'd0, hdr_block} - 32'd2;
              run_base = addr_ptr + blk_off * {20'd0, blk_size};
              if (run_base >= app_base) begin
                words = ({20'd0, hdr_len} + 32'd3) >> 2;
                if (words > 32'd1023) words = 32'd1023;
                queue_word(1'b1, 1'b1, '0, OP_PROGRAM, run_base, '0, words[9:0]);
              end
            end
          end else if (dfu_st == ST_MAN) begin
            clear_session();
            queue_word(1'b1, 1'b1, '0, OP_RESET, '0, '0, '0);
          end
        end
        default: begin
          queue_word(1'b0, 1'b0, '0, OP_NONE, '0, '0, '0);
        end
      endcase
    end
    burst[burst_n-1].last = 1'b1;
    for (k = 0; k < burst_n; k++) response_due.push_back(burst[k]);
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_session();
      app_base  = APP_BASE_RST;
      blk_size  = BLOCK_SIZE_RST;
      poll_dflt = POLL_RST;
      response_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(res_data_t)-1:0];
        if (response_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual kind %b last %b data %h",
                   $time, out_tuser, out_tlast, out_tdata);
          fails++;
        end else begin
          want = response_due.pop_front();
          compare_field("result_kind", 32'(want.kind), 32'(out_tuser));
          compare_field("last_result", 32'(want.last), 32'(out_tlast));
          compare_field("accepted", 32'(want.data.accepted), 32'(got.accepted));
          compare_field("poll_timeout", 32'(want.data.poll_timeout),
                        32'(got.poll_timeout));
          compare_field("reply_state", 32'(want.data.reply_state), 32'(got.reply_state));
          compare_field("flash_op", 32'(want.data.flash_op), 32'(got.flash_op));
          compare_field("flash_address", want.data.flash_address, got.flash_address);
          compare_field("sector_index", 32'(want.data.sector_index),
                        32'(got.sector_index));
          compare_field("word_count", 32'(want.data.word_count), 32'(got.word_count));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_APP_BASE:   app_base  = cfg_data;
          CFG_BLOCK_SIZE: blk_size  = cfg_data[11:0];
          CFG_POLL:       poll_dflt = cfg_data[23:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        predict_response(in_tuser, in_tdata[$bits(req_t)-1:0]);
    end
    errors  <= fails;
    pending <= response_due.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import dfu_pkg::*;

  localparam logic [7:0] REQ_UPLOAD    = 8'd2;
  localparam logic [7:0] REQ_UNDEFINED = 8'd7;
  localparam logic [7:0] CLASS_RT      = {1'b0, REQ_TYPE_CLASS};
  localparam int         CYCLE_LIMIT   = 400000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [7:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = '0;
  logic [31:0]           cfg_data = '0;
  int                    errors;
  int                    pending;

  int          cycle_count = 0;
  int          hold_left = 0;
  int          items_sent = 0;
  bit          idle_on = 1'b1;
  bit          paused = 1'b0;
  logic [31:0] app_base_now = APP_BASE_RST;
  logic [3:0]  sector_guess = 4'd1;

  dfu_download_state_machine_top dut (.*);
  dfu_response_checker checker_i (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      hold_left  <= $urandom_range(0, 14);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_req(input logic [7:0] code, input logic [7:0] rtype,
                          input logic [15:0] blk, input logic [11:0] len,
                          input logic [7:0] fb, input logic [31:0] fw);
    int   gap;
    logic ok;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= code;
    in_tdata  <= {4'b0, fw, fb, len, blk, rtype};
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
    if (rtype[6:0] == REQ_TYPE_CLASS &&
        (code == CMD_DNLOAD || code == CMD_GETSTATUS || code == CMD_CLRSTATUS ||
         code == CMD_GETSTATE || code == CMD_ABORT))
      items_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic load_registers(input logic [31:0] app, input logic [11:0] bsize,
                                input logic [23:0] poll);
    logic [31:0] vals[3];
    logic [1:0]  idx[3];
    logic        ok;
    vals = '{app, {20'd0, bsize}, {8'd0, poll}};
    idx  = '{CFG_APP_BASE, CFG_BLOCK_SIZE, CFG_POLL};
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= vals[k];
      do begin
        @(negedge clk);
        ok = cfg_ready;
        @(posedge clk);
      end while (!ok);
    end
    cfg_valid <= 1'b0;
    app_base_now = app;
  endtask

  task automatic random_transaction();
    int          pick;
    int          r;
    int          nblk;
    logic [7:0]  rt;
    logic [31:0] arg;
    logic [15:0] blk;
    logic [11:0] len;
    rt   = {1'($urandom), REQ_TYPE_CLASS};
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      r = $urandom_range(0, 9);
      if (r == 0) arg = app_base_now;
      else if (r == 1) arg = $urandom;
      else if (r == 2) arg = sec_base(4'($urandom_range(0, 15)));
      else arg = sec_base(sector_guess);
      send_req(CMD_DNLOAD, rt, 16'd0, 12'($urandom_range(1, 2048)), CODE_ERASE, arg);
      send_req(CMD_GETSTATUS, rt, 16'($urandom), 12'($urandom), 8'($urandom), $urandom);
      if (arg == sec_base(sector_guess) && arg >= app_base_now && sector_guess < SEC_LAST)
        sector_guess++;
      if ($urandom_range(0, 2) == 0) send_req(CMD_GETSTATUS, rt, '0, '0, '0, '0);
    end else if (pick < 45) begin
      r = $urandom_range(0, 3);
      if (r == 0) arg = app_base_now;
      else if (r == 1) arg = sec_base(4'($urandom_range(0, 15)));
      else if (r == 2) arg = $urandom;
      else arg = app_base_now + $urandom_range(0, 65535);
      send_req(CMD_DNLOAD, rt, 16'd0, 12'($urandom_range(1, 2048)), CODE_SETADDR, arg);
      send_req(CMD_GETSTATUS, rt, 16'($urandom), 12'($urandom), 8'($urandom), $urandom);
    end else if (pick < 75) begin
      r = $urandom_range(0, 9);
      if (r == 0) blk = 16'd1;
      else if (r == 1) blk = 16'($urandom);
      else blk = 16'($urandom_range(2, 40));
      nblk = $urandom_range(1, 4);
      for (int k = 0; k < nblk; k++) begin
        r = $urandom_range(0, 19);
        if (r == 0) len = 12'($urandom_range(2049, 4095));
        else if (r < 4) len = 12'($urandom_range(1, 8));
        else len = 12'($urandom_range(1, 2048));
        send_req(CMD_DNLOAD, rt, blk + 16'(k), len, 8'($urandom), $urandom);
        if ($urandom_range(0, 7) == 0) send_req(CMD_ABORT, rt, '0, '0, '0, '0);
        send_req(CMD_GETSTATUS, rt, 16'($urandom), 12'($urandom), 8'($urandom), $urandom);
      end
    end else if (pick < 80) begin
      send_req(CMD_DNLOAD, rt, 16'($urandom), 12'd0, 8'($urandom), $urandom);
      if ($urandom_range(0, 1) == 0) send_req(CMD_GETSTATE, rt, '0, '0, '0, '0);
      send_req(CMD_GETSTATUS, rt, 16'($urandom), 12'($urandom), 8'($urandom), $urandom);
      sector_guess = 4'd1;
    end else if (pick < 90) begin
      r = $urandom_range(0, 3);
      send_req(r == 0 ? CMD_GETSTATUS : r == 1 ? CMD_GETSTATE : r == 2 ? CMD_CLRSTATUS
                                                                     : CMD_ABORT,
               rt, 16'($urandom), 12'($urandom), 8'($urandom), $urandom);
    end else begin
      send_req(8'($urandom), 8'($urandom), 16'($urandom), 12'($urandom), 8'($urandom),
               $urandom);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(CMD_GETSTATE, CLASS_RT, '0, '0, '0, '0);
    send_req(CMD_GETSTATUS, 8'h00, 16'hFFFF, 12'hFFF, 8'hFF, 32'hFFFF_FFFF);
    send_req(CMD_GETSTATE, {1'b1, REQ_TYPE_CLASS}, '0, '0, '0, '0);
    send_req(REQ_UPLOAD, CLASS_RT, 16'd0, 12'd16, '0, '0);
    send_req(REQ_UNDEFINED, CLASS_RT, '0, '0, '0, '0);
    send_req(CMD_CLRSTATUS, CLASS_RT, '0, '0, '0, '0);
    send_req(CMD_ABORT, CLASS_RT, '0, '0, '0, '0);
    // erase of the first app sector: unprotect, erase, then idle status
    send_req(CMD_DNLOAD, CLASS_RT, 16'd0, 12'd5, CODE_ERASE, APP_BASE_RST);
    send_req(CMD_GETSTATUS, CLASS_RT, '0, '0, '0, '0);
    send_req(CMD_GETSTATUS, CLASS_RT, '0, '0, '0, '0);
    send_req(CMD_DNLOAD, CLASS_RT, 16'd0, 12'd5, CODE_SETADDR, 32'h0800_8000);
    send_req(CMD_GETSTATUS, CLASS_RT, '0, '0, '0, '0);
    send_req(CMD_DNLOAD, CLASS_RT, 16'd2, 12'd2048, 8'h00, 32'hFFFF_FFFF);
    send_req(CMD_GETSTATUS, CLASS_RT, '0, '0, '0, '0);
    // overlong payload on the highest block number
    send_req(CMD_DNLOAD, {1'b1, REQ_TYPE_CLASS}, 16'hFFFF, 12'hFFF, 8'hFF, 32'h0);
    send_req(CMD_GETSTATUS, CLASS_RT, '0, '0, '0, '0);
    send_req(CMD_DNLOAD, CLASS_RT, 16'd1, 12'd1, CODE_SETADDR, '0);
    send_req(CMD_GETSTATUS, CLASS_RT, '0, '0, '0, '0);
    send_req(CMD_DNLOAD, CLASS_RT, 16'd0, 12'd4, 8'h00, 32'h0800_C000);
    send_req(CMD_GETSTATUS, CLASS_RT, '0, '0, '0, '0);
    send_req(CMD_DNLOAD, CLASS_RT, 16'd3, 12'd16, '0, '0);
    send_req(CMD_ABORT, CLASS_RT, '0, '0, '0, '0);
    send_req(CMD_GETSTATUS, CLASS_RT, '0, '0, '0, '0);
    // manifest ends in a reset word
    send_req(CMD_DNLOAD, CLASS_RT, 16'd0, 12'd0, '0, '0);
    send_req(CMD_GETSTATUS, CLASS_RT, '0, '0, '0, '0);
    send_req(CMD_GETSTATE, CLASS_RT, '0, '0, '0, '0);
    drain();

    sector_guess = 4'd1;
    load_registers(APP_BASE_RST, BLOCK_SIZE_RST, POLL_RST);
    while (items_sent < 140) begin
      if (!paused && items_sent > 80) begin
        drain();
        paused = 1'b1;
      end
      random_transaction();
    end
    drain();

    load_registers(32'h0, 12'd1, 24'd0);
    while (items_sent < 260) random_transaction();
    drain();

    load_registers(32'hFFFF_FFFF, 12'd2048, 24'hFF_FFFF);
    while (items_sent < 380) random_transaction();
    drain();

    idle_on = 1'b0;
    load_registers(sec_base(4'($urandom_range(1, 11))), 12'($urandom_range(1, 2048)),
                   24'($urandom));
    while (items_sent < 450) random_transaction();
    drain();

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
